FILE: hdl/fmseq_pkg.sv
package fmseq_pkg;

	localparam int StepDepthDefault = 256;
	localparam int VoiceCountDefault = 3;
	localparam int QueueDepth = 4;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_START = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  voice;
		logic [7:0]  step_address;
		logic [7:0]  step_duration;
		logic [15:0] step_note_code;
		logic [3:0]  step_volume;
		logic        step_noise;
		logic        loop_enable;
		logic        sequence_present;
	} req_t;

	typedef struct packed {
		logic [7:0] reg_address;
		logic [7:0] reg_value;
		logic       last_write;
	} res_t;

	typedef struct packed {
		logic        noise;
		logic [3:0]  volume;
		logic [15:0] note;
		logic [7:0]  duration;
	} step_t;

	// Classified command handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_STOP  = 2'd0,
		CMD_START = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [1:0] voice;
		logic [7:0] address;
		logic       looping;
	} cmd_t;

	localparam logic [7:0] RegKey = 8'h08;
	localparam logic [7:0] RegNoise = 8'h0F;
	localparam logic [7:0] RegKeyCode = 8'h28;
	localparam logic [7:0] RegFraction = 8'h30;
	localparam logic [7:0] RegLevel = 8'h60;
	localparam logic [7:0] KeyOnMask = 8'h78;
	localparam logic [7:0] NoiseOn = 8'h90;
	localparam logic [7:0] LevelOff = 8'h7F;

	function automatic logic [2:0] chan_of(input logic [1:0] v);
		return (v == 2'd2) ? 3'd7 : v[0] ? 3'd1 : 3'd0;
	endfunction

endpackage

FILE: hdl/fm_note_step_sequencer.sv
// Channel   Direction  Handshake
// request   in         start, busy
// result    out        strobe (one cycle, no backpressure)
// config    in         APB psel, penable, pwrite, pready
// A tick visits each voice in a countdown state (S_VOICE) and a hand-off state (S_NEXT);
// a voice whose count expires reads the step store via S_READ, S_WAIT and S_CHECK (again
// when a loop restarts at its base) and forms its writes in S_EMIT. A start only sets voice
// state; a stop forms silence writes. Each write waits for the next; the last leaves at idle.
// Requests queue four deep; busy rises when that queue is full, and a step load waits
// until the queue has drained and the back end is idle.
// Reset clears all voices to inactive and the attenuations to 0, 4 and 0.
module fm_note_step_sequencer
	import fmseq_pkg::*;
#(
	parameter int STEP_DEPTH = StepDepthDefault,
	parameter int VOICE_COUNT = VoiceCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        request,
	output logic        strobe,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(STEP_DEPTH);

	logic          q_full, q_empty, q_push, q_pop, st_we, idle;
	cmd_t          q_data, q_head;
	logic [AW-1:0] st_waddr;
	step_t         st_wdata;
	logic [3:0]    atten_q [VOICE_COUNT];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atten_q[0] <= 4'd0;
			atten_q[1] <= 4'd4;
			atten_q[2] <= 4'd0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[3:2] != 2'd3) begin
			atten_q[paddr[3:2]] <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[3:2] != 2'd3) prdata[3:0] = atten_q[paddr[3:2]];
	end

	fmseq_front #(.STEP_DEPTH(STEP_DEPTH)) u_front (
		.start, .request, .q_full, .idle, .busy, .q_push, .q_data,
		.st_we, .st_waddr, .st_wdata
	);

	fmseq_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_data), .pop(q_pop),
		.full(q_full), .empty(q_empty), .head(q_head)
	);

	fmseq_back #(.STEP_DEPTH(STEP_DEPTH), .VOICE_COUNT(VOICE_COUNT)) u_back (
		.clk, .arst_n, .st_we, .st_waddr, .st_wdata, .q_empty, .q_head, .q_pop,
		.atten(atten_q), .idle, .strobe, .result
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("queue overflow");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> q_empty) else $error("idle with queued work");
`endif

endmodule

FILE: hdl/fmseq_front.sv
module fmseq_front
	import fmseq_pkg::*;
#(
	parameter int STEP_DEPTH = StepDepthDefault,
	localparam int AW = $clog2(STEP_DEPTH)
) (
	input  logic            start,
	input  req_t            request,
	input  logic            q_full,
	input  logic            idle,
	output logic            busy,
	output logic            q_push,
	output cmd_t            q_data,
	output logic            st_we,
	output logic [AW-1:0]   st_waddr,
	output step_t           st_wdata
);

	mode_t mode;
	logic  take;

	assign mode = mode_t'(request.mode);
	// A load must not overtake earlier requests that read the step store.
	assign busy = q_full || (mode == MODE_LOAD && !idle);
	assign take = start && !busy;

	always_comb begin
		q_push = 1'b0;
		st_we = 1'b0;
		q_data.kind = CMD_TICK;
		q_data.voice = request.voice;
		q_data.address = request.step_address;
		q_data.looping = request.loop_enable;
		case (mode)
			MODE_LOAD: st_we = take;
			MODE_START: begin
				q_push = take && (request.voice != 2'd3);
				q_data.kind = request.sequence_present ? CMD_START : CMD_STOP;
			end
			MODE_TICK: q_push = take;
			default: ;
		endcase
	end

	assign st_waddr = AW'(request.step_address);
	assign st_wdata = '{noise: request.step_noise, volume: request.step_volume,
		note: request.step_note_code, duration: request.step_duration};

endmodule

FILE: hdl/fmseq_queue.sv
module fmseq_queue
	import fmseq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int PW = $clog2(QueueDepth);

	cmd_t          slot_q [QueueDepth];
	logic [PW-1:0] rd_q, wr_q;
	logic [PW:0]   cnt_q;

	assign full = cnt_q == (PW+1)'(QueueDepth);
	assign empty = cnt_q == '0;
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

FILE: hdl/fmseq_back.sv
module fmseq_back
	import fmseq_pkg::*;
#(
	parameter int STEP_DEPTH = StepDepthDefault,
	parameter int VOICE_COUNT = VoiceCountDefault,
	localparam int AW = $clog2(STEP_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           st_we,
	input  logic [AW-1:0]  st_waddr,
	input  step_t          st_wdata,
	input  logic           q_empty,
	input  cmd_t           q_head,
	output logic           q_pop,
	input  logic [3:0]     atten [VOICE_COUNT],
	output logic           idle,
	output logic           strobe,
	output res_t           result
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_VOICE = 7'b0000010,
		S_READ  = 7'b0000100,
		S_WAIT  = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_NEXT  = 7'b1000000
	} state_t;

	step_t         mem [STEP_DEPTH];
	step_t         rd_q;
	logic [AW-1:0] raddr_q;
	state_t        state_q;
	cmd_t          cmd_q;
	logic [1:0]    v_q;
	logic          second_q;
	logic [7:0]    pos_q [VOICE_COUNT];
	logic [7:0]    base_q [VOICE_COUNT];
	logic [7:0]    cnt_q [VOICE_COUNT];
	logic          act_q [VOICE_COUNT];
	logic          loop_q [VOICE_COUNT];
	logic [3:0]    wi_q, wn_q;
	logic          play_q, pend_q;
	res_t          pend_r_q;
	logic [2:0]    ch;
	logic [7:0]    ch8;
	logic [3:0]    vol;
	logic [7:0]    wreg, wval;

	always_ff @(posedge clk) begin
		if (st_we) mem[st_waddr] <= st_wdata;
		rd_q <= mem[raddr_q];
	end

	assign ch = chan_of(v_q);
	assign ch8 = {5'd0, ch};
	assign vol = (rd_q.volume > atten[v_q]) ? rd_q.volume - atten[v_q] : 4'd0;

	// Write list: silence lists are index 0 (0,1 for voice 2); note lists 0..8, skipping 1 unless noisy or voice 2.
	always_comb begin
		wreg = RegKey;
		wval = ch8;
		case (wi_q)
			4'd0: ;
			4'd1: begin
				wreg = RegNoise;
				wval = (rd_q.noise && ch == 3'd7 && play_q) ? NoiseOn : 8'd0;
			end
			4'd2: begin wreg = RegKeyCode + ch8; wval = rd_q.note[15:8]; end
			4'd3: begin wreg = RegFraction + ch8; wval = {rd_q.note[5:0], 2'b00}; end
			4'd4: begin
				wreg = RegLevel + ch8;
				wval = 8'((5'd15 - {1'b0, vol}) * 7 + 6);
			end
			4'd5: begin wreg = RegLevel + 8'h08 + ch8; wval = LevelOff; end
			4'd6: begin wreg = RegLevel + 8'h10 + ch8; wval = LevelOff; end
			4'd7: begin wreg = KeyOnMask + ch8; wval = LevelOff; end
			4'd8: begin wreg = RegKey; wval = KeyOnMask | ch8; end
			default: ;
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign idle = (state_q == S_IDLE) && q_empty;

	// Each write is held until the next is formed so the final one of a request can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= 1'b0;
			strobe <= 1'b0;
			result <= '0;
			cmd_q <= '0;
			v_q <= '0;
			raddr_q <= '0;
			second_q <= 1'b0;
			wi_q <= '0;
			wn_q <= '0;
			play_q <= 1'b0;
			pend_r_q <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				pos_q[i] <= '0;
				base_q[i] <= '0;
				cnt_q[i] <= '0;
				act_q[i] <= 1'b0;
				loop_q[i] <= 1'b0;
			end
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						strobe <= 1'b1;
						result <= '{reg_address: pend_r_q.reg_address,
							reg_value: pend_r_q.reg_value, last_write: 1'b1};
						pend_q <= 1'b0;
					end
					if (!q_empty) begin
						cmd_q <= q_head;
						v_q <= (q_head.kind == CMD_TICK) ? 2'd0 : q_head.voice;
						if (q_head.kind == CMD_START) begin
							pos_q[q_head.voice] <= q_head.address;
							base_q[q_head.voice] <= q_head.address;
							cnt_q[q_head.voice] <= 8'd1;
							act_q[q_head.voice] <= 1'b1;
							loop_q[q_head.voice] <= q_head.looping;
						end else if (q_head.kind == CMD_STOP) begin
							act_q[q_head.voice] <= 1'b0;
							loop_q[q_head.voice] <= q_head.looping;
							play_q <= 1'b0;
							wi_q <= 4'd0;
							wn_q <= (q_head.voice == 2'd2) ? 4'd2 : 4'd1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_VOICE;
						end
					end
				end
				S_VOICE: begin
					if (act_q[v_q]) begin
						cnt_q[v_q] <= cnt_q[v_q] - 8'd1;
						if (cnt_q[v_q] == 8'd1) begin
							raddr_q <= AW'(pos_q[v_q]);
							second_q <= 1'b0;
							state_q <= S_READ;
						end else state_q <= S_NEXT;
					end else state_q <= S_NEXT;
				end
				S_READ: state_q <= S_WAIT;
				S_WAIT: state_q <= S_CHECK;
				S_CHECK: begin
					if (rd_q.duration == 8'd0) begin
						if (loop_q[v_q] && !second_q) begin
							pos_q[v_q] <= base_q[v_q];
							raddr_q <= AW'(base_q[v_q]);
							second_q <= 1'b1;
							state_q <= S_READ;
						end else begin
							act_q[v_q] <= 1'b0;
							play_q <= 1'b0;
							wi_q <= 4'd0;
							wn_q <= (v_q == 2'd2) ? 4'd2 : 4'd1;
							state_q <= S_EMIT;
						end
					end else begin
						cnt_q[v_q] <= rd_q.duration;
						pos_q[v_q] <= pos_q[v_q] + 8'd1;
						wi_q <= 4'd0;
						if (rd_q.note == 16'd0 && !rd_q.noise) begin
							play_q <= 1'b0;
							wn_q <= (v_q == 2'd2) ? 4'd2 : 4'd1;
						end else begin
							play_q <= 1'b1;
							wn_q <= 4'd9;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (pend_q) begin
						strobe <= 1'b1;
						result <= '{reg_address: pend_r_q.reg_address,
							reg_value: pend_r_q.reg_value, last_write: 1'b0};
					end
					pend_q <= 1'b1;
					pend_r_q <= '{reg_address: wreg, reg_value: wval, last_write: 1'b0};
					if (wi_q == 4'd0 && play_q && !rd_q.noise && ch != 3'd7)
						wi_q <= 4'd2;
					else
						wi_q <= wi_q + 4'd1;
					if (wi_q + 4'd1 == wn_q || (wi_q == 4'd0 && wn_q == 4'd1))
						state_q <= (cmd_q.kind == CMD_TICK) ? S_NEXT : S_IDLE;
				end
				S_NEXT: begin
					if (v_q == 2'(VOICE_COUNT - 1)) state_q <= S_IDLE;
					else begin
						v_q <= v_q + 2'd1;
						state_q <= S_VOICE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
